// ===== design/lcps_pkg.sv =====
// ============================================================================
// LED color palette sequencer package
// Shared types, action codes and defaults for the palette sequencer blocks.
// ============================================================================
package lcps_pkg;

   // Default number of palette entries
   localparam int DEF_PALETTE_DEPTH = 16;

   // Reset values of the configuration registers
   localparam logic [15:0] TICK_PERIOD_RST = 16'd1000;
   localparam logic [5:0]  LOOP_LIMIT_RST  = 6'h3f;   // -1: loop over all entries
   localparam logic [5:0]  LOOP_LIMIT_ALL  = 6'h3f;
   localparam logic [4:0]  POS_APPEND      = 5'h1f;   // -1 on add appends
   localparam logic [15:0] TICKS_MAX       = 16'hffff;

   // Input actions
   typedef enum logic [2:0] {
      ACT_ADD    = 3'd0,
      ACT_REMOVE = 3'd1,
      ACT_NEXT   = 3'd2,
      ACT_PREV   = 3'd3,
      ACT_TICK   = 3'd4,
      ACT_CLEAR  = 3'd5
   } action_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_TICK_PERIOD = 1'b0,
      CSR_LOOP_LIMIT  = 1'b1
   } csr_index_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_READ
   } state_type;

   // Configuration handed to the sequencer
   typedef struct packed {
      logic [15:0] tick_period;
      logic [5:0]  loop_limit;
   } cfg_type;

   // One result transaction
   typedef struct packed {
      logic       led_write;
      logic [7:0] led_red;
      logic [7:0] led_green;
      logic [7:0] led_blue;
      logic       status;
      logic [4:0] value;
      logic [4:0] entry_count;
      logic [3:0] play_position;
   } rsp_type;

endpackage

// ===== design/led_color_palette_sequencer.sv =====
// ============================================================================
// LED color palette sequencer
// Palette of RGB colors with add, remove, step, tick and clear actions.
// ============================================================================
// Usage:
//   req_* is a valid/ready channel carrying one action per transaction; rsp_*
//   returns exactly one result transaction per request, in order.
//   csr_write with csr_index/csr_data sets tick_period and loop_limit; write
//   only while the block is idle.
//   Add, clear, rejected items, unused actions, ticks that do not fire and
//   next or prev on an empty palette load the result register directly;
//   other next, prev and a firing tick pass through ST_READ (one palette
//   memory read); a remove at index p below count - 1 walks ST_SHIFT, one
//   palette entry moved per cycle through the single read and write port.
//   One request is in flight at a time; a new request is taken once the
//   previous result is in the output register and that register is empty or
//   being taken in the same cycle.
//   Reset empties the palette count, play index and tick counter and loads the
//   register defaults; palette contents are undefined until written.
//   A stalled receiver holds the result in the output register and blocks
//   further requests until it is taken.
// ============================================================================
module led_color_palette_sequencer import lcps_pkg::*; #(
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   // request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [4:0]  req_position,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   // result
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_led_write,
   output logic [7:0]  rsp_led_red,
   output logic [7:0]  rsp_led_green,
   output logic [7:0]  rsp_led_blue,
   output logic        rsp_status,
   output logic [4:0]  rsp_value,
   output logic [4:0]  rsp_entry_count,
   output logic [3:0]  rsp_play_position
);

   localparam int IDX_W = $clog2(PALETTE_DEPTH);

   cfg_type          cfg_ff;
   rsp_type          rsp;
   logic             mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [23:0]      mem_wr_data, mem_rd_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period <= TICK_PERIOD_RST;
         cfg_ff.loop_limit  <= LOOP_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_TICK_PERIOD: cfg_ff.tick_period <= csr_data;
            CSR_LOOP_LIMIT:  cfg_ff.loop_limit  <= csr_data[5:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Sequencer control
   lcps_ctrl #(
      .DEPTH (PALETTE_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_position (req_position),
      .req_color    ({req_in_red, req_in_green, req_in_blue}),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp          (rsp),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   // Palette store
   lcps_mem #(
      .DEPTH (PALETTE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_led_write     = rsp.led_write;
   assign rsp_led_red       = rsp.led_red;
   assign rsp_led_green     = rsp.led_green;
   assign rsp_led_blue      = rsp.led_blue;
   assign rsp_status        = rsp.status;
   assign rsp_value         = rsp.value;
   assign rsp_entry_count   = rsp.entry_count;
   assign rsp_play_position = rsp.play_position;

endmodule

// ===== design/lcps_mem.sv =====
// ============================================================================
// Palette memory
// Single write port, single read port, registered read data.
// ============================================================================
module lcps_mem import lcps_pkg::*; #(
   parameter int DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [23:0]              wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [23:0]              rd_data
);

   logic [23:0] mem [DEPTH];
   logic [23:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lcps_ctrl.sv =====
// ============================================================================
// Palette sequencer control
// Holds count, play index and tick counter, runs the remove shift loop and
// the palette reads, and keeps the result register.
// ============================================================================
module lcps_ctrl import lcps_pkg::*; #(
   parameter int DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   // request
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_action,
   input  logic [4:0]               req_position,
   input  logic [23:0]              req_color,
   // result
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp,
   // palette memory
   output logic                     mem_wr_en,
   output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
   output logic [23:0]              mem_wr_data,
   output logic                     mem_rd_en,
   output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
   input  logic [23:0]              mem_rd_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
   localparam int LW0   = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;
   localparam int LW    = (LW0 > 6) ? LW0 : 6;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   pidx_ff, pidx_in;
   logic [15:0]        elapsed_ff, elapsed_in;
   logic [IDX_W-1:0]   cursor_ff, cursor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_load;

   logic               accept;
   logic               pos_neg, pos_bad_neg;
   logic [CMP_W-1:0]   target, pos_u, cnt_c;
   logic               add_ok, add_grow, rm_ok, rm_shift, shift_more;
   logic [LW-1:0]      inc, cnt_l, lim_val;
   logic [IDX_W-1:0]   next_idx, prev_raw, prev_idx, tick_idx;
   logic               tick_wrap;
   logic [15:0]        ticks_inc;
   logic               tick_fire;
   logic [CNT_W-1:0]   rm_cnt;
   logic [IDX_W-1:0]   rm_pidx;

   // Operand decode
   always_comb begin
      pos_neg     = req_position[4];
      pos_bad_neg = pos_neg && (req_position != POS_APPEND);
      pos_u       = CMP_W'(req_position[3:0]);
      cnt_c       = CMP_W'(count_ff);
      target      = (req_position == POS_APPEND) ? cnt_c : pos_u;
      add_ok      = !pos_bad_neg && (target < CMP_W'(DEPTH));
      add_grow    = (target == cnt_c);
      rm_ok       = !pos_neg && (pos_u < cnt_c);
      rm_shift    = ((CMP_W + 1)'(pos_u) + 1'b1) < (CMP_W + 1)'(count_ff);
      shift_more  = ((LW + 1)'(cursor_ff) + 2'd2) < (LW + 1)'(count_ff);
   end

   // Play index steps
   always_comb begin
      inc      = LW'(pidx_ff) + 1'b1;
      cnt_l    = LW'(count_ff);
      lim_val  = LW'(cfg.loop_limit[4:0]);
      next_idx = (inc >= cnt_l) ? '0 : IDX_W'(inc);
      prev_raw = (pidx_ff == '0) ? IDX_W'(count_ff - 1'b1) : pidx_ff - 1'b1;
      prev_idx = (LW'(prev_raw) >= cnt_l) ? '0 : prev_raw;
      // wrap at min(loop limit, count); limits 32 to 62 always wrap
      if (cfg.loop_limit == LOOP_LIMIT_ALL) begin
         tick_wrap = (inc >= cnt_l);
      end else if (cfg.loop_limit[5]) begin
         tick_wrap = 1'b1;
      end else begin
         tick_wrap = (inc >= lim_val) || (inc >= cnt_l);
      end
      tick_idx  = tick_wrap ? '0 : IDX_W'(inc);
      ticks_inc = (elapsed_ff == TICKS_MAX) ? TICKS_MAX : elapsed_ff + 1'b1;
      tick_fire = (ticks_inc >= cfg.tick_period);
      // state after a successful remove
      rm_cnt    = count_ff - 1'b1;
      rm_pidx   = ((rm_cnt != '0) && (LW'(pidx_ff) >= LW'(rm_cnt)))
                  ? IDX_W'(rm_cnt - 1'b1) : pidx_ff;
   end

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Next state and memory control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pidx_in     = pidx_ff;
      elapsed_in  = elapsed_ff;
      cursor_in   = cursor_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cursor_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cursor_ff + 1'b1;
      rsp_load    = 1'b0;
      rsp_in      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_ADD: begin
                     rsp_load = 1'b1;
                     if (add_ok) begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = IDX_W'(target);
                        mem_wr_data  = req_color;
                        rsp_in.value = 5'(target);
                        if (add_grow) begin
                           count_in = count_ff + 1'b1;
                        end
                     end else begin
                        rsp_in.status = 1'b1;
                     end
                  end
                  ACT_REMOVE: begin
                     if (!rm_ok) begin
                        rsp_load      = 1'b1;
                        rsp_in.status = 1'b1;
                     end else if (rm_shift) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IDX_W'(pos_u) + 1'b1;
                        cursor_in   = IDX_W'(pos_u);
                        state_in    = ST_SHIFT;
                     end else begin
                        rsp_load     = 1'b1;
                        count_in     = rm_cnt;
                        pidx_in      = rm_pidx;
                        rsp_in.value = 5'(rm_cnt);
                     end
                  end
                  ACT_NEXT, ACT_PREV: begin
                     if (count_ff != '0) begin
                        pidx_in     = (req_action == ACT_NEXT) ? next_idx : prev_idx;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = pidx_in;
                        state_in    = ST_READ;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  ACT_TICK: begin
                     if (tick_fire) begin
                        elapsed_in  = '0;
                        pidx_in     = tick_idx;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = tick_idx;
                        state_in    = ST_READ;
                     end else begin
                        elapsed_in = ticks_inc;
                        rsp_load   = 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     pidx_in  = '0;
                     rsp_load = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // move entry cursor+1 down to cursor, fetch the one after
            mem_wr_en = 1'b1;
            cursor_in = cursor_ff + 1'b1;
            if (shift_more) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cursor_ff + IDX_W'(2);
            end else begin
               count_in     = rm_cnt;
               pidx_in      = rm_pidx;
               rsp_in.value = 5'(rm_cnt);
               rsp_load     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_in.led_write = 1'b1;
            if (count_ff != '0) begin
               rsp_in.led_red   = mem_rd_data[23:16];
               rsp_in.led_green = mem_rd_data[15:8];
               rsp_in.led_blue  = mem_rd_data[7:0];
            end
            rsp_load = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.entry_count   = 5'(count_in);
      rsp_in.play_position = 4'(pidx_in);

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pidx_ff      <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pidx_ff      <= pidx_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Shift cursor and result payload
   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
